### hdl/sm64bd_pkg.sv
// ----------------------------------------------------------------------------
// sm64bd_pkg
// Types and constants shared by the SplitMix64 bounded draw block.
// ----------------------------------------------------------------------------
package sm64bd_pkg;

   localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

   localparam int unsigned SHIFT_0 = 30;
   localparam int unsigned SHIFT_1 = 27;
   localparam int unsigned SHIFT_2 = 31;

   localparam logic [1:0] PHASE_LAST = 2'd2;
   localparam logic [5:0] DIV_LAST   = 6'd63;

   localparam logic OP_RAW     = 1'b0;
   localparam logic OP_BOUNDED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XS,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

### hdl/splitmix64_bounded_draw.sv
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw
// SplitMix64 generator with a raw draw and a bounded draw by restoring modulo.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | opcode, range_low, range_high
//  rsp     | out       | rsp_valid/rsp_stall  | raw_value, bounded_value
//  csr     | in        | csr_wr_en            | csr_wr_data (seed)
//
//  One item at a time through a single 32x32 multiplier and a 34-bit subtractor.
//  Raw draw: from accept to result register, 3 xor-shifts, 2x3 multiply steps and
//  one load.
//  Bounded draw: the raw draw, then the modulo at one bit a cycle over all 64 bits.
//  Equal or inverted range (high <= low): the state is not advanced.
//  req_stall is high from accept until the result enters the output register; a stalled
//  result is held there while the next item is taken. Reset is synchronous, state 0.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [63:0] rsp_raw_value,
   output logic signed [31:0] rsp_bounded_value,
   input  logic               csr_wr_en,
   input  logic        [63:0] csr_wr_data
);

   sm64bd_pkg::state_type state_ff, state_in;
   logic [63:0] gen_ff, gen_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] raw_ff, raw_in;
   logic [32:0] span_ff, span_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] lo_ff, lo_in;
   logic        op_ff, op_in;
   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_raw_ff, rsp_raw_in;
   logic [31:0] rsp_bnd_ff, rsp_bnd_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] mul_k;
   logic [63:0] z_xs;
   logic [33:0] trial;
   logic [33:0] diff;

   assign req_stall         = (state_ff != sm64bd_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_raw_value     = rsp_raw_ff;
   assign rsp_bounded_value = rsp_bnd_ff;

   assign mul_k = phase_ff[0] ? sm64bd_pkg::MIX_MUL_B : sm64bd_pkg::MIX_MUL_A;
   assign mul_a = (cnt_ff[1:0] == 2'd2) ? z_ff[63:32] : z_ff[31:0];
   assign mul_b = (cnt_ff[1:0] == 2'd1) ? mul_k[63:32] : mul_k[31:0];
   assign prod  = {32'b0, mul_a} * {32'b0, mul_b};

   assign trial = {rem_ff, z_ff[63]};
   assign diff  = trial - {1'b0, span_ff};

   always_comb begin
      case (phase_ff)
         2'd0:    z_xs = z_ff ^ (z_ff >> sm64bd_pkg::SHIFT_0);
         2'd1:    z_xs = z_ff ^ (z_ff >> sm64bd_pkg::SHIFT_1);
         default: z_xs = z_ff ^ (z_ff >> sm64bd_pkg::SHIFT_2);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      raw_in       = raw_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_bnd_in   = rsp_bnd_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sm64bd_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               lo_in  = req_range_low;
               rem_in = '0;
               if (req_opcode == sm64bd_pkg::OP_BOUNDED && req_range_high <= req_range_low) begin
                  raw_in   = '0;
                  state_in = sm64bd_pkg::ST_DONE;
               end else begin
                  gen_in   = gen_ff + sm64bd_pkg::GOLDEN_INC;
                  z_in     = gen_ff + sm64bd_pkg::GOLDEN_INC;
                  span_in  = {req_range_high[31], req_range_high}
                           - {req_range_low[31], req_range_low} + 33'd1;
                  phase_in = '0;
                  cnt_in   = '0;
                  state_in = sm64bd_pkg::ST_XS;
               end
            end
         end
         sm64bd_pkg::ST_XS: begin
            z_in   = z_xs;
            cnt_in = '0;
            if (phase_ff == sm64bd_pkg::PHASE_LAST) begin
               raw_in   = z_xs;
               state_in = (op_ff == sm64bd_pkg::OP_BOUNDED) ? sm64bd_pkg::ST_DIV
                                                            : sm64bd_pkg::ST_DONE;
            end else begin
               state_in = sm64bd_pkg::ST_MUL;
            end
         end
         sm64bd_pkg::ST_MUL: begin
            cnt_in = cnt_ff + 6'd1;
            case (cnt_ff[1:0])
               2'd0: begin
                  acc_in = prod;
               end
               2'd1: begin
                  acc_in = acc_ff + {prod[31:0], 32'b0};
               end
               default: begin
                  z_in     = acc_ff + {prod[31:0], 32'b0};
                  phase_in = phase_ff + 2'd1;
                  state_in = sm64bd_pkg::ST_XS;
               end
            endcase
         end
         sm64bd_pkg::ST_DIV: begin
            rem_in = diff[33] ? trial[32:0] : diff[32:0];
            z_in   = {z_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == sm64bd_pkg::DIV_LAST) begin
               state_in = sm64bd_pkg::ST_DONE;
            end
         end
         sm64bd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_raw_in   = raw_ff;
               rsp_bnd_in   = (op_ff == sm64bd_pkg::OP_BOUNDED) ? (lo_ff + rem_ff[31:0]) : '0;
               state_in     = sm64bd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sm64bd_pkg::ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         gen_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sm64bd_pkg::ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff       <= z_in;
      acc_ff     <= acc_in;
      raw_ff     <= raw_in;
      span_ff    <= span_in;
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      op_ff      <= op_in;
      rsp_raw_ff <= rsp_raw_in;
      rsp_bnd_ff <= rsp_bnd_in;
   end

endmodule
